// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the datapath RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMMN_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("implication check failed");

// next-cycle implication
`define SMMN_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/smmn_pkg.sv =====
// ----------------------------------------------------------------------------
// smmn_pkg
// Types and constants for the Sobel magnitude / min-max normalise block.
// ----------------------------------------------------------------------------
package smmn_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_FRAC_BITS  = 4;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int WREG_W     = 11;
	localparam int HREG_W     = 13;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam logic [WREG_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [HREG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

	localparam int COL_OUT_W = 10;
	localparam int ROW_OUT_W = 12;
	localparam int QUOT_W    = 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WIN,
		S_SQR,
		S_RLOAD,
		S_ROOT,
		S_EVAL,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic window;
		logic square;
		logic root_load;
		logic root_step;
		logic minmax;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic interior;
		logic emit;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/smmn_ifs.sv =====
// ----------------------------------------------------------------------------
// smmn channel interfaces
// Pixel input, edge result output and configuration write channels.
// ----------------------------------------------------------------------------
interface smmn_pix_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] pixel;
	modport source (output valid, func, pixel, input ready);
	modport sink   (input valid, func, pixel, output ready);
endinterface

interface smmn_edge_if;
	logic        valid;
	logic        ready;
	logic [7:0]  edge_value;
	logic [9:0]  out_col;
	logic [11:0] out_row;
	logic        frame_last;
	modport source (output valid, edge_value, out_col, out_row, frame_last, input ready);
	modport sink   (input valid, edge_value, out_col, out_row, frame_last, output ready);
endinterface

interface smmn_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sobel_magnitude_minmax_normalize.sv =====
// ----------------------------------------------------------------------------
// sobel_magnitude_minmax_normalize
// 3x3 Sobel edge magnitude over a twice-streamed frame, min/max normalised.
// ----------------------------------------------------------------------------
// Usage:
//  pixels : raster-order grey pixels with func (0 = measure, 1 = emit).
//  edges  : one result per interior pixel in the emit pass, with its column,
//           row and a last flag on the final interior pixel. Borders give none.
//  cfg    : index 0 image_width, index 1 image_height; write while idle.
//  A pixel steps through accept, window, square, root load, the root steps
//  and evaluation; the square root produces one bit per cycle in a shared
//  iterative unit. Interior emit-pass pixels add the divider load, the
//  divide steps and the output load; the result is valid the cycle after that.
//  The output register holds a result until taken; the next pixel is accepted
//  meanwhile, and the sequencer only waits if a second result is ready
//  while the first is still stalled.
//  Reset returns the counters, window and min/max to their start values;
//  line stores are not cleared, which no result depends on.
// ----------------------------------------------------------------------------
module sobel_magnitude_minmax_normalize
	import smmn_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	smmn_pix_if.sink    pixels,
	smmn_edge_if.source edges,
	smmn_cfg_if.sink    cfg
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign pixels.ready = in_ready;

	smmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smmn_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.pixels (pixels),
		.cfg    (cfg),
		.edges  (edges)
	);

endmodule

// ===== rtl/smmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// smmn_ctrl
// Sequencer: steps one pixel through window, square, root and divide.
// ----------------------------------------------------------------------------
module smmn_ctrl
	import smmn_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_WIN;
				end
			end
			S_WIN: begin
				cmd.window = 1'b1;
				state_d    = S_SQR;
			end
			S_SQR: begin
				cmd.square = 1'b1;
				state_d    = S_RLOAD;
			end
			S_RLOAD: begin
				cmd.root_load = 1'b1;
				state_d       = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_done) state_d = S_EVAL;
			end
			S_EVAL: begin
				priority if (!sts.interior) begin
					state_d = S_IDLE;
				end else if (!sts.emit) begin
					cmd.minmax = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== rtl/smmn_datapath.sv =====
// ----------------------------------------------------------------------------
// smmn_datapath
// Line stores, window, counters, Sobel sums, bit-serial root and divider,
// min/max tracking and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smmn_datapath
	import smmn_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	output sts_t          sts,
	smmn_pix_if.sink      pixels,
	smmn_cfg_if.sink      cfg,
	smmn_edge_if.source   edges
);

	localparam int CW       = $clog2(MAX_WIDTH);
	localparam int WW       = $clog2(MAX_WIDTH + 1);
	localparam int RW_      = $clog2(MAX_HEIGHT);
	localparam int HW       = $clog2(MAX_HEIGHT + 1);
	localparam int MAG_BITS = 11 + FRAC_BITS;
	localparam int RADW     = 2 * MAG_BITS;
	localparam int REMW     = MAG_BITS + 3;
	localparam int RCW      = $clog2(MAG_BITS);
	localparam int NUMW     = MAG_BITS + QUOT_W;

	// configuration
	logic [WREG_W-1:0] wreg_q;
	logic [HREG_W-1:0] hreg_q;
	logic [WW-1:0]     w_use;
	logic [HW-1:0]     h_use;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wreg_q <= RST_IMAGE_WIDTH;
			hreg_q <= RST_IMAGE_HEIGHT;
		end else if (cfg.valid) begin
			if (cfg.index == REG_IMAGE_WIDTH)  wreg_q <= cfg.data[WREG_W-1:0];
			if (cfg.index == REG_IMAGE_HEIGHT) hreg_q <= cfg.data[HREG_W-1:0];
		end
	end

	always_comb begin
		if (32'(wreg_q) < 32'd3)              w_use = WW'(3);
		else if (32'(wreg_q) > 32'(MAX_WIDTH)) w_use = WW'(MAX_WIDTH);
		else                                   w_use = WW'(wreg_q);
		if (32'(hreg_q) < 32'd3)                h_use = HW'(3);
		else if (32'(hreg_q) > 32'(MAX_HEIGHT)) h_use = HW'(MAX_HEIGHT);
		else                                    h_use = HW'(hreg_q);
	end

	// line stores
	logic [7:0] up_mem  [MAX_WIDTH];
	logic [7:0] mid_mem [MAX_WIDTH];
	logic [7:0] t2_q, m2_q, pix_q;
	logic       func_q;
	logic [7:0] win_q [6];
	logic [CW-1:0]  col_q;
	logic [RW_-1:0] row_q;
	logic [CW-1:0]  ccol_q;
	logic [RW_-1:0] crow_q;
	logic           interior_q, last_q;
	logic           col_end, row_end;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t2_q   <= up_mem[col_q];
			m2_q   <= mid_mem[col_q];
			pix_q  <= pixels.pixel;
			func_q <= pixels.func;
			ccol_q <= col_q;
			crow_q <= row_q;
		end
		if (cmd.window) begin
			up_mem[ccol_q]  <= m2_q;
			mid_mem[ccol_q] <= pix_q;
		end
	end

	assign col_end = ({1'b0, ccol_q} >= ((CW + 1)'(w_use) - 1'b1));
	assign row_end = ({1'b0, crow_q} >= ((RW_ + 1)'(h_use) - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (cmd.window) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= t2_q;
			win_q[4] <= m2_q;
			win_q[5] <= pix_q;
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Sobel sums
	logic signed [11:0] gx_w, gy_w;
	logic signed [10:0] gx_q, gy_q;

	always_comb begin
		gx_w = (12'(t2_q) + (12'(m2_q) << 1) + 12'(pix_q))
		     - (12'(win_q[0]) + (12'(win_q[1]) << 1) + 12'(win_q[2]));
		gy_w = (12'(win_q[2]) + (12'(win_q[5]) << 1) + 12'(pix_q))
		     - (12'(win_q[0]) + (12'(win_q[3]) << 1) + 12'(t2_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.window) begin
			gx_q       <= gx_w[10:0];
			gy_q       <= gy_w[10:0];
			interior_q <= (ccol_q >= CW'(2)) && (crow_q >= RW_'(2));
			last_q     <= col_end && row_end;
		end
	end

	// squares
	logic signed [21:0] sqx_q, sqy_q;
	logic [21:0]        sq_sum;

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			sqx_q <= gx_q * gx_q;
			sqy_q <= gy_q * gy_q;
		end
	end

	assign sq_sum = {1'b0, sqx_q[20:0]} + {1'b0, sqy_q[20:0]};

	// square root, two radicand bits a step
	logic [RADW-1:0]     rad_q;
	logic [REMW-1:0]     rem_q;
	logic [MAG_BITS-1:0] root_q;
	logic [RCW-1:0]      rcnt_q;
	logic [REMW-1:0]     rem_sh, trial;

	assign rem_sh = {rem_q[REMW-3:0], rad_q[RADW-1:RADW-2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rad_q  <= RADW'(sq_sum) << (2 * FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
			rcnt_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rcnt_q <= rcnt_q + 1'b1;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[MAG_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[MAG_BITS-2:0], 1'b0};
			end
		end
	end

	assign sts.root_done = (rcnt_q == RCW'(MAG_BITS - 1));

	// min / max
	logic [MAG_BITS-1:0] min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (cmd.accept && !pixels.func && col_q == '0 && row_q == '0) begin
			min_q <= '1;
			max_q <= '0;
		end else if (cmd.minmax) begin
			if (root_q < min_q) min_q <= root_q;
			if (root_q > max_q) max_q <= root_q;
		end
	end

	// scale: 255 * (mag - min) / (max - min), one quotient bit a step
	logic [MAG_BITS-1:0] mclamp, mdiff;
	logic [NUMW-1:0]     num_q, dsh_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [2:0]          dcnt_q;
	logic                flat_q;

	always_comb begin
		if (root_q < min_q)      mclamp = min_q;
		else if (root_q > max_q) mclamp = max_q;
		else                     mclamp = root_q;
		mdiff = mclamp - min_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q  <= (NUMW'(mdiff) << QUOT_W) - NUMW'(mdiff);
			dsh_q  <= NUMW'(max_q - min_q) << (QUOT_W - 1);
			flat_q <= !(max_q > min_q);
			quot_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + 1'b1;
			dsh_q  <= dsh_q >> 1;
			if (num_q >= dsh_q) begin
				num_q  <= num_q - dsh_q;
				quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
			end
		end
	end

	assign sts.div_done = (dcnt_q == 3'(QUOT_W - 1));
	assign sts.interior = interior_q;
	assign sts.emit     = func_q;

	// result register
	logic        out_valid_q;
	logic [7:0]  edge_q;
	logic [9:0]  ocol_q;
	logic [11:0] orow_q;
	logic        olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (edges.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			edge_q  <= flat_q ? 8'hFF : ~quot_q;
			ocol_q  <= COL_OUT_W'(32'(ccol_q) - 32'd1);
			orow_q  <= ROW_OUT_W'(32'(crow_q) - 32'd1);
			olast_q <= last_q;
		end
	end

	assign sts.out_busy     = out_valid_q && !edges.ready;
	assign edges.valid      = out_valid_q;
	assign edges.edge_value = edge_q;
	assign edges.out_col    = ocol_q;
	assign edges.out_row    = orow_q;
	assign edges.frame_last = olast_q;

	`SMMN_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_q && !edges.ready))
	`SMMN_ASSERT_NXT(a_accept_then_window, cmd.accept, cmd.window)
	`SMMN_ASSERT_NXT(a_range_ordered, cmd.minmax, min_q <= max_q)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sobel edge magnitude block: frames are streamed as a measure pass and then
// an emit pass at several frame sizes, with random gaps on both channels.
// A scoreboard predicts every edge result and checks it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import smmn_pkg::*;

	localparam int MAG_ONES    = 32'h7FFF;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE_CYC  = 40;

	typedef struct packed {
		logic [7:0]  edge_value;
		logic [9:0]  col;
		logic [11:0] row;
		logic        last;
	} edge_t;

	class edge_scoreboard;
		int unsigned width_reg, height_reg;
		bit [7:0]    line_upper[DEF_MAX_WIDTH];
		bit [7:0]    line_middle[DEF_MAX_WIDTH];
		bit [7:0]    win[6];
		int unsigned col, row, mag_min, mag_max;
		edge_t       pending[$];
		int          errors;

		function new();
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			foreach (line_upper[i]) begin
				line_upper[i] = 0;
				line_middle[i] = 0;
			end
			foreach (win[i]) win[i] = 0;
			col = 0;
			row = 0;
			mag_min = MAG_ONES;
			mag_max = 0;
			errors = 0;
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function int unsigned int_sqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return int'(res);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = d[WREG_W-1:0];
			else if (idx == REG_IMAGE_HEIGHT)
				height_reg = d[HREG_W-1:0];
		endfunction

		function bit at_origin();
			return col == 0 && row == 0;
		endfunction

		function void note_pixel(bit f, bit [7:0] p);
			int unsigned w, h, mag, inten, m;
			int t0, m0, l0, t1, m1, l1, t2, m2, l2, gx, gy;
			longint unsigned sq;
			edge_t e;
			w = clamp(width_reg, 3, DEF_MAX_WIDTH);
			h = clamp(height_reg, 3, DEF_MAX_HEIGHT);
			if (!f && col == 0 && row == 0) begin
				mag_min = MAG_ONES;
				mag_max = 0;
			end
			t2 = 0;
			m2 = 0;
			if (col < DEF_MAX_WIDTH) begin
				t2 = line_upper[col];
				m2 = line_middle[col];
				line_upper[col] = 8'(m2);
				line_middle[col] = p;
			end
			l2 = p;
			t0 = win[0]; m0 = win[1]; l0 = win[2];
			t1 = win[3]; m1 = win[4]; l1 = win[5];
			gx = (t2 + 2 * m2 + l2) - (t0 + 2 * m0 + l0);
			gy = (l0 + 2 * l1 + l2) - (t0 + 2 * t1 + t2);
			sq = longint'(gx * gx) + longint'(gy * gy);
			mag = int_sqrt(sq << (2 * DEF_FRAC_BITS)) & MAG_ONES;
			if (col >= 2 && row >= 2) begin
				if (!f) begin
					if (mag < mag_min) mag_min = mag;
					if (mag > mag_max) mag_max = mag;
				end else begin
					inten = 0;
					if (mag_max > mag_min) begin
						m = clamp(mag, mag_min, mag_max);
						inten = (255 * (m - mag_min)) / (mag_max - mag_min);
					end
					e.edge_value = 8'(255 - inten);
					e.col = 10'(col - 1);
					e.row = 12'(row - 1);
					e.last = (col >= w - 1 && row >= h - 1);
					pending.push_back(e);
				end
			end
			win[0] = 8'(t1); win[1] = 8'(m1); win[2] = 8'(l1);
			win[3] = 8'(t2); win[4] = 8'(m2); win[5] = 8'(l2);
			if (col >= w - 1) begin
				col = 0;
				row = (row >= h - 1) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_edge(edge_t got);
			edge_t exp_e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected edge result col %0d row %0d value %0d",
					$time, got.col, got.row, got.edge_value);
				errors++;
				return;
			end
			exp_e = pending.pop_front();
			if (got.edge_value !== exp_e.edge_value) begin
				$display("%0t: edge_value expected %0d actual %0d", $time,
					exp_e.edge_value, got.edge_value);
				errors++;
			end
			if (got.col !== exp_e.col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, exp_e.col, got.col);
				errors++;
			end
			if (got.row !== exp_e.row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, exp_e.row, got.row);
				errors++;
			end
			if (got.last !== exp_e.last) begin
				$display("%0t: frame_last expected %0d actual %0d", $time,
					exp_e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	smmn_pix_if  pix_ch ();
	smmn_edge_if edge_ch ();
	smmn_cfg_if  cfg_ch ();

	sobel_magnitude_minmax_normalize DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch.sink),
		.edges  (edge_ch.source),
		.cfg    (cfg_ch.sink)
	);

	edge_scoreboard sb = new();
	bit             quiet;
	int             stall_left;
	int             idle_cycles;
	int             sent_items;
	bit [7:0]       flat_level;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// most gaps short, a few long; none at all during quiet stretches
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			edge_ch.ready = 1'b0;
			stall_left--;
		end else begin
			stall_left = gap_len();
			edge_ch.ready = (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (edge_ch.valid && edge_ch.ready)
				sb.check_edge({edge_ch.edge_value, edge_ch.out_col, edge_ch.out_row,
					edge_ch.frame_last});
			if ((edge_ch.valid && edge_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_pixel(bit f, bit [7:0] p);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			pix_ch.valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_ch.valid = 1'b1;
		pix_ch.func = f;
		pix_ch.pixel = p;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note_pixel(f, p);
		sent_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		// a pixel with no result may still be in the sequencer
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = d;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		drain();
		write_cfg(REG_IMAGE_WIDTH, w);
		write_cfg(REG_IMAGE_HEIGHT, h);
	endtask

	// feed random pixels until the raster position is back at the origin
	task automatic realign();
		while (!sb.at_origin())
			send_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	function automatic bit [7:0] pattern_px(int kind, int c, int r);
		case (kind)
			1: return flat_level;
			2: return ((c + r) % 2) ? 8'd255 : 8'd0;
			3: return 8'((c * 37 + r * 11) & 8'hFF);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// measure pass then emit pass; mixed picks func per pixel at random
	task automatic run_frame(int w, int h, int kind_m, int kind_e, bit mixed, int rows);
		int kind;
		bit f;
		for (int pass = 0; pass < 2; pass++) begin
			kind = pass ? kind_e : kind_m;
			for (int r = 0; r < rows; r++)
				for (int c = 0; c < w; c++) begin
					f = mixed ? bit'($urandom_range(0, 1)) : bit'(pass);
					send_pixel(f, pattern_px(kind, c, r));
				end
		end
	endtask

	initial begin
		int w, h, k;
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.func = 1'b0;
		pix_ch.pixel = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_IMAGE_WIDTH;
		cfg_ch.data = '0;
		edge_ch.ready = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		sent_items = 0;
		quiet = 1'b0;
		flat_level = 8'd77;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// a part row at the reset size, then an emit pass with nothing
		// measured: all results are 255
		repeat (8) send_pixel(1'b1, 8'($urandom_range(0, 255)));
		set_size(3, 3);
		while (!sb.at_origin()) send_pixel(1'b1, 8'($urandom_range(0, 255)));
		repeat (9) send_pixel(1'b1, 8'($urandom_range(0, 255)));
		run_frame(3, 3, 2, 2, 1'b0, 3);
		flat_level = 8'd0;
		run_frame(3, 3, 1, 2, 1'b0, 3);
		set_size(4, 4);
		flat_level = 8'd200;
		run_frame(4, 4, 1, 1, 1'b0, 4);
		// out-of-range registers clamp to the minimum
		set_size(0, 1);
		realign();
		run_frame(3, 3, 0, 0, 1'b0, 3);
		set_size(5, 4);
		run_frame(5, 4, 0, 3, 1'b1, 4);
		realign();
		// width register all ones clamps to the maximum; part of a row only
		quiet = 1'b1;
		set_size(13'h1FFF, 3);
		repeat (40) send_pixel(1'b0, 8'($urandom_range(0, 255)));
		set_size(3, 3);
		realign();
		// tallest frame, only the first rows are streamed
		set_size(3, 13'h1FFF);
		run_frame(3, 4096, 0, 2, 1'b0, 6);
		quiet = 1'b0;
		set_size(6, 5);
		realign();

		while (sent_items < 450) begin
			quiet = ($urandom_range(0, 5) == 0);
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 6);
			k = $urandom_range(0, 9);
			flat_level = 8'($urandom_range(0, 255));
			set_size(13'(w), 13'(h));
			realign();
			if (k == 0)
				run_frame(w, h, 0, 0, 1'b1, h);
			else if (k == 1)
				run_frame(w, h, 0, 0, 1'b0, $urandom_range(1, h - 1));
			else
				run_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 3), 1'b0, h);
		end
		quiet = 1'b0;
		drain();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sobel_magnitude_minmax_normalize.f =====
+incdir+rtl
rtl/smmn_pkg.sv
rtl/smmn_ifs.sv
rtl/smmn_ctrl.sv
rtl/smmn_datapath.sv
rtl/sobel_magnitude_minmax_normalize.sv
tb/sv/tb_top.sv
